// ----- rtl/mcla_pkg.sv -----
// ----------------------------------------------------------------------------
// mcla_pkg
// Shared constants and control types for the multi-channel line assembler.
// ----------------------------------------------------------------------------
package mcla_pkg;

   localparam int LINE_BYTES_DEF = 64;
   localparam int CHANNELS_DEF   = 2;

   localparam logic [7:0] BYTE_CR = 8'd13;
   localparam logic [7:0] BYTE_LF = 8'd10;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;         // an input beat is accepted this cycle
      logic fetch;        // read the line store at the current index
      logic load_byte;    // move the fetched byte into the output register
      logic load_reject;  // put a reject beat into the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ch_valid;     // the incoming channel exists
      logic is_term;      // the incoming byte is CR or LF
      logic is_ovf;       // the incoming channel has overflowed
      logic is_empty;     // the incoming channel holds no bytes
      logic out_free;     // the output register can take a beat this cycle
      logic at_last;      // the current index is the last byte of the line
   } status_type;

endpackage

// ----- rtl/mcla_ctrl.sv -----
// ----------------------------------------------------------------------------
// mcla_ctrl
// Sequencer that accepts bytes and steps the readout of a finished line.
// ----------------------------------------------------------------------------
module mcla_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  mcla_pkg::status_type status,
   output mcla_pkg::cmd_type    cmd
);
   import mcla_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_REJECT
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      cmd         = '0;
      state_in    = state_ff;
      cmd.take    = req_tvalid & ready_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.take && status.ch_valid && status.is_term) begin
               if (status.is_ovf) begin
                  state_in = ST_REJECT;
               end else if (!status.is_empty) begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load_byte = 1'b1;
               state_in      = status.at_last ? ST_IDLE : ST_FETCH;
            end
         end
         ST_REJECT: begin
            if (status.out_free) begin
               cmd.load_reject = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      ready_in = (state_in == ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_tready = ready_ff;

endmodule

// ----- rtl/mcla_datapath.sv -----
// ----------------------------------------------------------------------------
// mcla_datapath
// Per-channel line stores, counts and overflow flags, plus the output register.
// ----------------------------------------------------------------------------
module mcla_datapath #(
   parameter int LINE_BYTES = mcla_pkg::LINE_BYTES_DEF,
   parameter int CHANNELS   = mcla_pkg::CHANNELS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_channel,
   input  logic [7:0]           req_byte,
   input  mcla_pkg::cmd_type    cmd,
   output mcla_pkg::status_type status,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic                 rsp_channel,
   output logic [7:0]           rsp_byte,
   output logic                 rsp_last,
   output logic                 rsp_too_long
);
   import mcla_pkg::*;

   localparam int LEN_W = $clog2(LINE_BYTES);
   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_BYTES - 1);

   logic [7:0]       line_mem [CHANNELS][LINE_BYTES];
   logic [LEN_W-1:0] len_ff   [CHANNELS];
   logic             ovf_ff   [CHANNELS];

   logic [CH_W-1:0]  cur_ch_ff;
   logic [LEN_W-1:0] idx_ff;
   logic [LEN_W-1:0] last_ff;
   logic [7:0]       rd_data_ff;

   logic             out_valid_ff, out_valid_in;
   logic             out_ch_ff;
   logic [7:0]       out_byte_ff;
   logic             out_last_ff;
   logic             out_rej_ff;

   logic             ch_valid;
   logic [CH_W-1:0]  ch_idx;
   logic [LEN_W-1:0] cur_len;
   logic             is_term;

   assign ch_valid = (32'(req_channel) < CHANNELS);
   assign ch_idx   = ch_valid ? CH_W'(req_channel) : '0;
   assign cur_len  = len_ff[ch_idx];
   assign is_term  = (req_byte == BYTE_CR) || (req_byte == BYTE_LF);

   always_comb begin
      status          = '0;
      status.ch_valid = ch_valid;
      status.is_term  = is_term;
      status.is_ovf   = ovf_ff[ch_idx];
      status.is_empty = (cur_len == '0);
      status.out_free = !out_valid_ff || rsp_tready;
      status.at_last  = (idx_ff == last_ff);
   end

   // Counts and overflow flags: bytes append, terminators clear the channel.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CHANNELS; c++) begin
            len_ff[c] <= '0;
            ovf_ff[c] <= 1'b0;
         end
      end else if (cmd.take && ch_valid) begin
         if (is_term) begin
            len_ff[ch_idx] <= '0;
            ovf_ff[ch_idx] <= 1'b0;
         end else if (cur_len < LEN_MAX) begin
            len_ff[ch_idx] <= cur_len + 1'b1;
         end else begin
            ovf_ff[ch_idx] <= 1'b1;
         end
      end
   end

   // Line store: one write port at accept, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.take && ch_valid && !is_term && (cur_len < LEN_MAX)) begin
         line_mem[ch_idx][cur_len] <= req_byte;
      end
      if (cmd.fetch) begin
         rd_data_ff <= line_mem[cur_ch_ff][idx_ff];
      end
   end

   // Readout context captured when a terminator arrives.
   always_ff @(posedge clock) begin
      if (cmd.take && ch_valid && is_term) begin
         cur_ch_ff <= ch_idx;
         last_ff   <= cur_len - 1'b1;
         idx_ff    <= '0;
      end else if (cmd.load_byte) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   // Output register.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_byte || cmd.load_reject) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // The reject beat takes its channel from the captured context, since the
   // input may already carry the next byte by the time the beat is loaded.
   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         out_ch_ff   <= cur_ch_ff[0];
         out_byte_ff <= rd_data_ff;
         out_last_ff <= (idx_ff == last_ff);
         out_rej_ff  <= 1'b0;
      end else if (cmd.load_reject) begin
         out_ch_ff   <= cur_ch_ff[0];
         out_byte_ff <= 8'd0;
         out_last_ff <= 1'b1;
         out_rej_ff  <= 1'b1;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_channel  = out_ch_ff;
   assign rsp_byte     = out_byte_ff;
   assign rsp_last     = out_last_ff;
   assign rsp_too_long = out_rej_ff;

endmodule

// ----- rtl/multi_channel_line_assembler_top.sv -----
// ----------------------------------------------------------------------------
// multi_channel_line_assembler_top
// Assembles CR/LF-terminated text lines from bytes of several channels.
// ----------------------------------------------------------------------------
// The req channel carries one received byte per beat in tdata, tagged with its
// source channel in tuser. Ordinary bytes are appended to that channel's line
// store as they are accepted, so back-to-back bytes are accepted at one per
// cycle while no line is being read out. A CR or LF byte finishes the line. A
// good line is sent on the rsp channel as one beat per stored byte, with tlast
// on the final one. An overflowed line is sent as one beat with too_long set,
// zero data and tlast. An empty line sends nothing. For each byte of a line,
// the readout first does a registered read of the line store and then loads
// the byte into the output register; the next read begins only once that byte
// is loaded. The req side is not ready while a line is read out. When the
// receiver stalls, the current beat holds in the output register and the
// readout waits. Reset clears all counts, overflow flags and the output valid
// flag; the line store itself needs no clearing.
// ----------------------------------------------------------------------------
module multi_channel_line_assembler_top #(
   parameter int LINE_BYTES = mcla_pkg::LINE_BYTES_DEF,
   parameter int CHANNELS   = mcla_pkg::CHANNELS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic [0:0] req_tuser,   // [0] channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] line_byte
   output logic       rsp_tlast,
   output logic [1:0] rsp_tuser    // [0] line_channel, [1] too_long
);
   import mcla_pkg::*;

   cmd_type    cmd;
   status_type status;

   logic rsp_channel;
   logic rsp_too_long;

   // The controller sequences acceptance and the line readout.
   mcla_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the line stores and drives the result register.
   mcla_datapath #(
      .LINE_BYTES (LINE_BYTES),
      .CHANNELS   (CHANNELS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_channel  (req_tuser[0]),
      .req_byte     (req_tdata),
      .cmd          (cmd),
      .status       (status),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_channel  (rsp_channel),
      .rsp_byte     (rsp_tdata),
      .rsp_last     (rsp_tlast),
      .rsp_too_long (rsp_too_long)
   );

   assign rsp_tuser = {rsp_too_long, rsp_channel};

endmodule
